@@ design/dcfd_pkg.sv @@
package dcfd_pkg;

  // Opcodes that the back end carries out
  localparam logic [5:0] OP_FULL_SYNC   = 6'h29;
  localparam logic [5:0] OP_SCISSOR     = 6'h2D;
  localparam logic [5:0] OP_OTHER_MODES = 6'h2F;
  localparam logic [5:0] OP_COMBINE     = 6'h3C;

  // Opcodes with a length other than two words
  localparam logic [5:0] OP_TRI              = 6'h08;
  localparam logic [5:0] OP_TRI_Z            = 6'h09;
  localparam logic [5:0] OP_TRI_TEX          = 6'h0A;
  localparam logic [5:0] OP_TRI_TEX_Z        = 6'h0B;
  localparam logic [5:0] OP_TRI_SHADE        = 6'h0C;
  localparam logic [5:0] OP_TRI_SHADE_Z      = 6'h0D;
  localparam logic [5:0] OP_TRI_SHADE_TEX    = 6'h0E;
  localparam logic [5:0] OP_TRI_SHADE_TEX_Z  = 6'h0F;
  localparam logic [5:0] OP_TEX_RECT         = 6'h24;
  localparam logic [5:0] OP_TEX_RECT_FLIP    = 6'h25;

  localparam int MIN_LEN = 2;
  localparam int MAX_LEN = 63;

  // A completed command: its first and its last word
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  opcode;
    logic        sync_interrupt;
    logic        unhandled;
    logic [9:0]  scissor_x_high;
    logic [9:0]  scissor_y_high;
    logic [9:0]  scissor_x_low;
    logic [9:0]  scissor_y_low;
    logic [55:0] combine_settings;
    logic [49:0] other_mode_settings;
  } res_t;

  // Command length in words; long_len is the length of the largest triangle
  function automatic logic [5:0] command_len(logic [5:0] op, logic [5:0] long_len);
    logic [5:0] len;
    unique case (op)
      OP_TRI:             len = 6'd8;
      OP_TRI_Z:           len = 6'd12;
      OP_TRI_TEX:         len = 6'd24;
      OP_TRI_TEX_Z:       len = 6'd28;
      OP_TRI_SHADE:       len = 6'd24;
      OP_TRI_SHADE_Z:     len = 6'd28;
      OP_TRI_SHADE_TEX:   len = 6'd40;
      OP_TRI_SHADE_TEX_Z: len = long_len;
      OP_TEX_RECT:        len = 6'd4;
      OP_TEX_RECT_FLIP:   len = 6'd4;
      default:            len = 6'd2;
    endcase
    return len;
  endfunction

endpackage

@@ design/dcfd_front.sv @@
module dcfd_front #(
  parameter int MAX_COMMAND_WORDS = 44
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [31:0]        command_word_i,
  output logic               full_o,
  output logic               cmd_push_o,
  output dcfd_pkg::cmd_t     cmd_o,
  input  logic               cmd_full_i
);
  import dcfd_pkg::*;

  localparam int ClampedLen = (MAX_COMMAND_WORDS < MIN_LEN) ? MIN_LEN :
                              (MAX_COMMAND_WORDS > MAX_LEN) ? MAX_LEN : MAX_COMMAND_WORDS;
  localparam logic [5:0] LongLen = 6'(ClampedLen);

  logic [5:0]  words_left_q, words_left_d;
  logic [31:0] held_q, held_d;
  logic        accept;

  assign full_o = cmd_full_i;
  assign accept = push_i && !full_o;

  always_comb begin
    words_left_d = words_left_q;
    held_d       = held_q;
    cmd_push_o   = 1'b0;
    if (accept) begin
      if (words_left_q == 6'd0) begin
        held_d       = command_word_i;
        words_left_d = command_len(command_word_i[29:24], LongLen) - 6'd1;
      end else begin
        words_left_d = words_left_q - 6'd1;
        cmd_push_o   = (words_left_q == 6'd1);
      end
    end
  end

  assign cmd_o.first = held_q;
  assign cmd_o.last  = command_word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= 6'd0;
      held_q       <= 32'd0;
    end else begin
      words_left_q <= words_left_d;
      held_q       <= held_d;
    end
  end

endmodule

@@ design/dcfd_cmd_fifo.sv @@
module dcfd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcfd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dcfd_pkg::cmd_t cmd_o
);
  import dcfd_pkg::*;

  localparam int Depth = 2;

  cmd_t       entry_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ design/dcfd_back.sv @@
module dcfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  dcfd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dcfd_pkg::res_t res_o
);
  import dcfd_pkg::*;

  logic        valid_q;
  logic [5:0]  opcode_q, opcode_d;
  logic        sync_q, sync_d;
  logic        unh_q, unh_d;
  logic [39:0] scissor_q, scissor_d;
  logic [55:0] combine_q, combine_d;
  logic [49:0] other_q, other_d;
  logic        take;

  // Advance when the output slot is free or being emptied this cycle
  assign take      = !cmd_empty_i && (!valid_q || pop_i);
  assign cmd_pop_o = take;
  assign empty_o   = !valid_q;

  always_comb begin
    opcode_d  = cmd_i.first[29:24];
    sync_d    = 1'b0;
    unh_d     = 1'b0;
    scissor_d = scissor_q;
    combine_d = combine_q;
    other_d   = other_q;
    unique case (opcode_d)
      OP_FULL_SYNC:   sync_d = 1'b1;
      OP_SCISSOR:     scissor_d = {cmd_i.first[23:14], cmd_i.first[11:2],
                                   cmd_i.last[23:14], cmd_i.last[11:2]};
      OP_OTHER_MODES: other_d = {cmd_i.first[21:4], cmd_i.last};
      OP_COMBINE:     combine_d = {cmd_i.first[23:0], cmd_i.last};
      default:        unh_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      opcode_q  <= 6'd0;
      sync_q    <= 1'b0;
      unh_q     <= 1'b0;
      scissor_q <= 40'd0;
      combine_q <= 56'd0;
      other_q   <= 50'd0;
    end else begin
      if (take) begin
        valid_q   <= 1'b1;
        opcode_q  <= opcode_d;
        sync_q    <= sync_d;
        unh_q     <= unh_d;
        scissor_q <= scissor_d;
        combine_q <= combine_d;
        other_q   <= other_d;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Stores only change when the next command is taken from the queue, so they can drive the ports
  assign res_o.opcode              = opcode_q;
  assign res_o.sync_interrupt      = sync_q;
  assign res_o.unhandled           = unh_q;
  assign res_o.scissor_x_high      = scissor_q[39:30];
  assign res_o.scissor_y_high      = scissor_q[29:20];
  assign res_o.scissor_x_low       = scissor_q[19:10];
  assign res_o.scissor_y_low       = scissor_q[9:0];
  assign res_o.combine_settings    = combine_q;
  assign res_o.other_mode_settings = other_q;

endmodule

@@ design/display_command_framer_decoder.sv @@
// Display-list command framer and decoder.
// Input channel: one 32-bit display-list word per transaction, taken at a
// rising edge with push_i high and full_o low. The first word of a command
// carries the opcode in bits 29..24; its length in words comes from a fixed
// table (the largest triangle's length is MAX_COMMAND_WORDS, held to 2..63).
// Result channel: one result per completed command, shown while empty_o is
// low and taken at a rising edge with pop_i high. Each result carries the
// opcode, the sync and unhandled flags, and the latched scissor, combine and
// other-mode fields as they stand after the command.
// Throughput: one word per cycle while full_o is low. The framer counts
// words; a two-entry command queue feeds the decoder, which completes one
// command per cycle into a single output register refilled when popped.
// A completed command enters the command queue, then the output register.
// When pop_i stays low, the command queue fills and full_o rises; words are
// then held off until results are taken again.
// Reset clears the word count, the held first word, all latched fields and
// both queues; the block takes words in the first cycle after reset.
module display_command_framer_decoder #(
  parameter int MAX_COMMAND_WORDS = 44
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] command_word_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [5:0]  opcode_o,
  output logic        sync_interrupt_o,
  output logic        unhandled_o,
  output logic [9:0]  scissor_x_high_o,
  output logic [9:0]  scissor_y_high_o,
  output logic [9:0]  scissor_x_low_o,
  output logic [9:0]  scissor_y_low_o,
  output logic [55:0] combine_settings_o,
  output logic [49:0] other_mode_settings_o
);
  import dcfd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_t res;

  dcfd_front #(
    .MAX_COMMAND_WORDS(MAX_COMMAND_WORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .command_word_i (command_word_i),
    .full_o         (full_o),
    .cmd_push_o     (cmd_push),
    .cmd_o          (front_cmd),
    .cmd_full_i     (cmd_full)
  );

  dcfd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (back_cmd)
  );

  dcfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .res_o       (res)
  );

  assign opcode_o              = res.opcode;
  assign sync_interrupt_o      = res.sync_interrupt;
  assign unhandled_o           = res.unhandled;
  assign scissor_x_high_o      = res.scissor_x_high;
  assign scissor_y_high_o      = res.scissor_y_high;
  assign scissor_x_low_o       = res.scissor_x_low;
  assign scissor_y_low_o       = res.scissor_y_low;
  assign combine_settings_o    = res.combine_settings;
  assign other_mode_settings_o = res.other_mode_settings;

endmodule
